// ----- hw/rtl/vm3_pkg.sv -----
package vm3_pkg;

    // width of one signed vector component
    localparam int COMPONENT_WIDTH = 16;
    // width of the magnitude result
    localparam int MAG_WIDTH = 16;

    localparam int SQ_WIDTH   = 2 * COMPONENT_WIDTH;
    // three squares summed, two guard bits keep the width even
    localparam int SUM_WIDTH  = SQ_WIDTH + 2;
    // one root bit per cell
    localparam int ROOT_WIDTH = SUM_WIDTH / 2;
    localparam int REM_WIDTH  = ROOT_WIDTH + 2;
    localparam int NUM_CELLS  = ROOT_WIDTH;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_WIDTH = ((3 * COMPONENT_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((MAG_WIDTH + 7) / 8) * 8;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef logic [COMPONENT_WIDTH-1:0] comp_abs_t;
    typedef logic [SQ_WIDTH-1:0] square_t;
    typedef logic [SUM_WIDTH-1:0] sum_t;
    typedef logic [ROOT_WIDTH-1:0] root_t;
    typedef logic [REM_WIDTH-1:0] rem_t;
    typedef logic [MAG_WIDTH-1:0] mag_t;

    // work carried from one root cell to the next
    typedef struct packed {
        sum_t  radicand;
        rem_t  remainder;
        root_t root;
    } sqrt_work_t;

    // magnitude of a two's complement component; the most negative value maps
    // to its true magnitude as an unsigned number
    function automatic comp_abs_t comp_abs(input comp_t value);
        comp_abs_t result;
        if (value[COMPONENT_WIDTH-1]) begin
            result = comp_abs_t'(-value);
        end else begin
            result = comp_abs_t'(value);
        end
        return result;
    endfunction

    // clamp the root to the magnitude width
    function automatic mag_t mag_saturate(input root_t root);
        logic [ROOT_WIDTH+MAG_WIDTH-1:0] wide;
        mag_t result;
        wide = {{MAG_WIDTH{1'b0}}, root};
        if (wide[ROOT_WIDTH+MAG_WIDTH-1:MAG_WIDTH] != '0) begin
            result = '1;
        end else begin
            result = wide[MAG_WIDTH-1:0];
        end
        return result;
    endfunction

endpackage

// ----- hw/rtl/vm3_sumsq.sv -----
module vm3_sumsq
    import vm3_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  comp_t vec_x,
    input  comp_t vec_y,
    input  comp_t vec_z,
    output logic  out_valid,
    input  logic  out_ready,
    output sum_t  out_sum
);

    logic    sq_valid_reg, sq_valid_next;
    square_t sq_x_reg, sq_y_reg, sq_z_reg;
    logic    sum_valid_reg, sum_valid_next;
    sum_t    sum_reg;
    logic    sq_ready, sum_ready;

    assign sum_ready = !sum_valid_reg || out_ready;
    assign sq_ready  = !sq_valid_reg || sum_ready;
    assign in_ready  = sq_ready;

    always_comb begin
        sq_valid_next  = sq_ready ? in_valid : sq_valid_reg;
        sum_valid_next = sum_ready ? sq_valid_reg : sum_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            sq_valid_reg  <= sq_valid_next;
            sum_valid_reg <= sum_valid_next;
        end
    end

    // squares, one multiplier per component
    always_ff @(posedge aclk) begin
        if (sq_ready && in_valid) begin
            sq_x_reg <= square_t'(comp_abs(vec_x)) * square_t'(comp_abs(vec_x));
            sq_y_reg <= square_t'(comp_abs(vec_y)) * square_t'(comp_abs(vec_y));
            sq_z_reg <= square_t'(comp_abs(vec_z)) * square_t'(comp_abs(vec_z));
        end
    end

    // exact sum of the three squares
    always_ff @(posedge aclk) begin
        if (sum_ready && sq_valid_reg) begin
            sum_reg <= sum_t'(sq_x_reg) + sum_t'(sq_y_reg) + sum_t'(sq_z_reg);
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_sum   = sum_reg;

endmodule

// ----- hw/rtl/vm3_sqrt_cell.sv -----
module vm3_sqrt_cell
    import vm3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  sqrt_work_t in_work,
    output logic       out_valid,
    input  logic       out_ready,
    output sqrt_work_t out_work
);

    logic       valid_reg, valid_next;
    sqrt_work_t work_reg, work_next;
    rem_t       rem_shift, trial;
    logic       fits;

    assign in_ready = !valid_reg || out_ready;

    // one restoring step: bring down two radicand bits, try a one bit
    always_comb begin
        rem_shift = {in_work.remainder[REM_WIDTH-3:0],
                     in_work.radicand[SUM_WIDTH-1:SUM_WIDTH-2]};
        trial     = {in_work.root, 2'b01};
        fits      = (rem_shift >= trial);
        work_next.radicand  = {in_work.radicand[SUM_WIDTH-3:0], 2'b00};
        work_next.remainder = fits ? (rem_shift - trial) : rem_shift;
        work_next.root      = {in_work.root[ROOT_WIDTH-2:0], fits};
        valid_next          = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ----- hw/rtl/vector_magnitude_3d_core.sv -----
// Euclidean length of a signed Q6.10 3D vector, returned as an unsigned Q6.10
// magnitude: floor(sqrt(x*x + y*y + z*z)), computed exactly with no rounding.
// One request is taken per clock when the result side does not stall, and one
// result comes out per request, in order. The squares are registered, then their
// sum, then the work in the chain of root cells, one root bit per cell (seventeen
// cells at the default component width). Each stage has its own valid flag, so
// back-pressure on the result side only stops stages that are full and
// gaps in the stream are squeezed out. No configuration and no state.
module vector_magnitude_3d_core
    import vm3_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // request channel
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,  // vec_x, vec_y, vec_z from bit 0 up
    // result channel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata   // magnitude, zero padded above
);

    comp_t vec_x, vec_y, vec_z;

    logic sum_valid, sum_ready;
    sum_t sum;

    // handshake and work between neighbouring cells; index 0 feeds the first
    logic       cell_valid [NUM_CELLS+1];
    logic       cell_ready [NUM_CELLS+1];
    sqrt_work_t cell_work  [NUM_CELLS+1];

    // unpack the request fields
    assign vec_x = s_tdata[COMPONENT_WIDTH-1:0];
    assign vec_y = s_tdata[2*COMPONENT_WIDTH-1:COMPONENT_WIDTH];
    assign vec_z = s_tdata[3*COMPONENT_WIDTH-1:2*COMPONENT_WIDTH];

    // squares and their exact sum
    vm3_sumsq u_sumsq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum)
    );

    // seed the root chain with an empty remainder and root
    assign cell_valid[0]          = sum_valid;
    assign sum_ready              = cell_ready[0];
    assign cell_work[0].radicand  = sum;
    assign cell_work[0].remainder = '0;
    assign cell_work[0].root      = '0;

    // one root bit per cell, most significant first
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        vm3_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_work   (cell_work[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_work  (cell_work[i+1])
        );
    end

    // last cell register doubles as the result register
    assign m_tvalid              = cell_valid[NUM_CELLS];
    assign cell_ready[NUM_CELLS] = m_tready;
    assign m_tdata = M_TDATA_WIDTH'(mag_saturate(cell_work[NUM_CELLS].root));

endmodule
